// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cbsm_pkg.sv =====
// Types and constants for the circular byte store.
`default_nettype none

package cbsm_pkg;

  localparam int unsigned IDX_FIELD_W = 6;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned ADDR_W      = 16;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;
  localparam logic [LEN_W-1:0] MAX_READ = 7'd64;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_MOVE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  typedef enum logic {
    ALU_INC    = 1'b0,
    ALU_REDUCE = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_REDUCE,
    S_RD_ADDR,
    S_RD_EMIT,
    S_MV_LOAD,
    S_MV_SAVE,
    S_MV_FETCH,
    S_MV_STORE,
    S_MV_DONE
  } state_e;

  typedef struct packed {
    cmd_e                   command;
    logic [7:0]             data_byte;
    logic                   first;
    logic [LEN_W-1:0]       length;
    logic [ADDR_W-1:0]      target_address;
    logic [IDX_FIELD_W-1:0] source_index;
    logic [IDX_FIELD_W-1:0] dest_index;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [7:0]             read_byte;
    logic [IDX_FIELD_W-1:0] start_index;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic re;
    logic tmp_we;
    logic tmp_re;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cbsm_alu.sv =====
// Shared index unit: wrap-around increment and reduce-by-size step.
`default_nettype none

module cbsm_alu #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic [cbsm_pkg::LEN_W-1:0] a_i,
  input  cbsm_pkg::alu_op_e          op_i,
  output logic [cbsm_pkg::LEN_W-1:0] y_o,
  output logic                       ge_o
);

  localparam logic [cbsm_pkg::LEN_W-1:0] Size = cbsm_pkg::LEN_W'(STORE_BYTES);

  logic [cbsm_pkg::LEN_W-1:0] sum;

  assign sum  = a_i + 7'd1;
  assign ge_o = (a_i >= Size);

  always_comb begin
    case (op_i)
      cbsm_pkg::ALU_INC:    y_o = (sum == Size) ? '0 : sum;
      cbsm_pkg::ALU_REDUCE: y_o = ge_o ? (a_i - Size) : a_i;
      default:              y_o = a_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cbsm_store.sv =====
// Byte store with per-entry valid flags, plus the scratch buffer for moves.
`default_nettype none

module cbsm_store #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cbsm_pkg::mem_ctrl_t            ctrl_i,
  input  logic [$clog2(STORE_BYTES)-1:0] waddr_i,
  input  logic [7:0]                     wdata_i,
  input  logic [$clog2(STORE_BYTES)-1:0] raddr_i,
  output logic [7:0]                     rdata_o,
  input  logic [$clog2(STORE_BYTES)-1:0] tmp_addr_i,
  input  logic [7:0]                     tmp_wdata_i,
  output logic [7:0]                     tmp_rdata_o
);

  logic [7:0]             mem_q [STORE_BYTES];
  logic [7:0]             tmp_q [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid_q;
  logic [7:0]             rdata_q;
  logic                   rvalid_q;
  logic [7:0]             tmp_rdata_q;

  // Entries never written read back as space.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.we) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q  <= mem_q[raddr_i];
      rvalid_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tmp_we) begin
      tmp_q[tmp_addr_i] <= tmp_wdata_i;
    end
    if (ctrl_i.tmp_re) begin
      tmp_rdata_q <= tmp_q[tmp_addr_i];
    end
  end

  assign rdata_o     = rvalid_q ? rdata_q : cbsm_pkg::SPACE_CHAR;
  assign tmp_rdata_o = tmp_rdata_q;

endmodule

`default_nettype wire

// ===== rtl/circular_byte_store_with_move.sv =====
// Circular byte store: append and addressed write runs, read runs, moves.
//
//   port group       direction  handshake         payload
//   cfg_we_i/data_i  in         write enable      base_address, 16 bits
//   in_valid_i       in         valid/ready       cbsm_pkg::in_item_t
//   out_valid_o      out        valid/ready       cbsm_pkg::out_item_t
//
// Write bytes (append or addressed) are taken without leaving idle; a first
// byte also loads one result into the output register.
// Read run: the source index is reduced by STORE_BYTES until in range, then
// each byte: memory read, then emit, which waits while the output stalls.
// Move run: each byte passes through the scratch buffer, then one result.
// After reset no clearing pass runs: per-entry valid flags make unwritten
// entries read as space. Items are taken only in idle with the output free.
`default_nettype none

module circular_byte_store_with_move #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cbsm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbsm_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = $clog2(STORE_BYTES);
  localparam int unsigned CntW = $clog2(STORE_BYTES + 1);
  localparam int unsigned LenW = cbsm_pkg::LEN_W;
  localparam logic [LenW-1:0] Size = LenW'(STORE_BYTES);

  cbsm_pkg::state_e state_q, state_d;

  logic [15:0]                        base_q;
  logic [IdxW-1:0]                    tail_q, tail_d;
  logic [CntW-1:0]                    used_q, used_d;
  logic                               run_open_q, run_open_d;
  logic                               run_acc_q, run_acc_d;
  logic                               run_app_q, run_app_d;
  logic [IdxW-1:0]                    run_widx_q, run_widx_d;
  logic [LenW-1:0]                    run_rem_q, run_rem_d;
  logic [cbsm_pkg::IDX_FIELD_W-1:0]   idx_q, idx_d;
  logic [cbsm_pkg::IDX_FIELD_W-1:0]   start_q, start_d;
  logic [LenW-1:0]                    n_q, n_d;
  logic [LenW-1:0]                    k_q, k_d;
  logic                               out_valid_q, out_valid_d;
  cbsm_pkg::out_item_t                out_data_q, out_data_d;

  // datapath helpers
  logic                accept;
  logic                out_free;
  logic                is_wr;
  logic [LenW-1:0]     n_wr;
  logic [LenW-1:0]     free_cnt;
  logic                no_space;
  logic [16:0]         offset;
  logic                bad_addr;
  cbsm_pkg::status_e   first_status;
  logic [IdxW-1:0]     first_start;
  logic                eff_acc;
  logic                eff_app;
  logic [IdxW-1:0]     eff_widx;
  logic [LenW-1:0]     eff_rem;
  logic                take;
  logic [LenW-1:0]     len_rd;
  logic [LenW-1:0]     len_mv;
  logic                mv_bad;
  logic                k_last;

  // shared unit and store
  logic [LenW-1:0]     alu_a, alu_y;
  logic                alu_ge;
  cbsm_pkg::alu_op_e   alu_op;
  cbsm_pkg::mem_ctrl_t mem_ctrl;
  logic [IdxW-1:0]     mem_waddr;
  logic [7:0]          mem_wdata;
  logic [7:0]          mem_rdata;
  logic [7:0]          tmp_rdata;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign k_last   = ((k_q + 7'd1) == n_q);

  // write-run bookkeeping
  assign is_wr    = (in_data_i.command == cbsm_pkg::CMD_APPEND) ||
                    (in_data_i.command == cbsm_pkg::CMD_WRITE);
  assign n_wr     = (in_data_i.length == '0) ? 7'd1 : in_data_i.length;
  assign free_cnt = Size - LenW'(used_q);
  assign no_space = (free_cnt < n_wr);
  assign offset   = {1'b0, in_data_i.target_address} - {1'b0, base_q};
  assign bad_addr = offset[16] || (offset[15:0] >= 16'(STORE_BYTES));

  always_comb begin
    if (no_space) begin
      first_status = cbsm_pkg::ST_NO_SPACE;
    end else if ((in_data_i.command == cbsm_pkg::CMD_WRITE) && bad_addr) begin
      first_status = cbsm_pkg::ST_BAD_ADDR;
    end else begin
      first_status = cbsm_pkg::ST_OK;
    end
  end

  assign first_start = (in_data_i.command == cbsm_pkg::CMD_APPEND) ? tail_q
                                                                   : offset[IdxW-1:0];
  assign eff_acc  = in_data_i.first ? (first_status == cbsm_pkg::ST_OK) : run_acc_q;
  assign eff_app  = in_data_i.first ? (in_data_i.command == cbsm_pkg::CMD_APPEND)
                                    : run_app_q;
  assign eff_widx = in_data_i.first ? first_start : run_widx_q;
  assign eff_rem  = in_data_i.first ? n_wr : run_rem_q;
  assign take     = is_wr && (in_data_i.first || run_open_q);

  assign len_rd = (in_data_i.length > cbsm_pkg::MAX_READ) ? cbsm_pkg::MAX_READ
                                                          : in_data_i.length;
  assign len_mv = (in_data_i.length > Size) ? Size : in_data_i.length;
  assign mv_bad = ({1'b0, in_data_i.source_index} >= Size) ||
                  ({1'b0, in_data_i.dest_index} >= Size);

  cbsm_alu #(
    .STORE_BYTES(STORE_BYTES)
  ) u_alu (
    .a_i (alu_a),
    .op_i(alu_op),
    .y_o (alu_y),
    .ge_o(alu_ge)
  );

  cbsm_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mem_ctrl),
    .waddr_i    (mem_waddr),
    .wdata_i    (mem_wdata),
    .raddr_i    (idx_q[IdxW-1:0]),
    .rdata_o    (mem_rdata),
    .tmp_addr_i (k_q[IdxW-1:0]),
    .tmp_wdata_i(mem_rdata),
    .tmp_rdata_o(tmp_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbsm_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_data_i.command == cbsm_pkg::CMD_READ) && (len_rd != '0)) begin
            state_d = cbsm_pkg::S_RD_REDUCE;
          end else if ((in_data_i.command == cbsm_pkg::CMD_MOVE) && !mv_bad &&
                       (len_mv != '0)) begin
            state_d = cbsm_pkg::S_MV_LOAD;
          end
        end
      end
      cbsm_pkg::S_RD_REDUCE: if (!alu_ge) state_d = cbsm_pkg::S_RD_ADDR;
      cbsm_pkg::S_RD_ADDR:   state_d = cbsm_pkg::S_RD_EMIT;
      cbsm_pkg::S_RD_EMIT: begin
        if (out_free) begin
          state_d = k_last ? cbsm_pkg::S_IDLE : cbsm_pkg::S_RD_ADDR;
        end
      end
      cbsm_pkg::S_MV_LOAD:   state_d = cbsm_pkg::S_MV_SAVE;
      cbsm_pkg::S_MV_SAVE:   state_d = k_last ? cbsm_pkg::S_MV_FETCH : cbsm_pkg::S_MV_LOAD;
      cbsm_pkg::S_MV_FETCH:  state_d = cbsm_pkg::S_MV_STORE;
      cbsm_pkg::S_MV_STORE:  state_d = k_last ? cbsm_pkg::S_MV_DONE : cbsm_pkg::S_MV_FETCH;
      cbsm_pkg::S_MV_DONE:   if (out_free) state_d = cbsm_pkg::S_IDLE;
      default:               state_d = cbsm_pkg::S_IDLE;
    endcase
  end

  // FSM outputs: handshake, store strobes, shared unit control
  always_comb begin
    in_ready_o = 1'b0;
    mem_ctrl   = '0;
    mem_waddr  = idx_q[IdxW-1:0];
    mem_wdata  = tmp_rdata;
    alu_op     = cbsm_pkg::ALU_INC;
    alu_a      = {1'b0, idx_q};
    case (state_q)
      cbsm_pkg::S_IDLE: begin
        in_ready_o  = out_free;
        alu_a       = LenW'(eff_widx);
        mem_waddr   = eff_widx;
        mem_wdata   = in_data_i.data_byte;
        mem_ctrl.we = in_valid_i && out_free && take && (eff_rem != '0) && eff_acc;
      end
      cbsm_pkg::S_RD_REDUCE: alu_op = cbsm_pkg::ALU_REDUCE;
      cbsm_pkg::S_RD_ADDR:   mem_ctrl.re = 1'b1;
      cbsm_pkg::S_MV_LOAD:   mem_ctrl.re = 1'b1;
      cbsm_pkg::S_MV_SAVE:   mem_ctrl.tmp_we = 1'b1;
      cbsm_pkg::S_MV_FETCH:  mem_ctrl.tmp_re = 1'b1;
      cbsm_pkg::S_MV_STORE:  mem_ctrl.we = 1'b1;
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    tail_d      = tail_q;
    used_d      = used_q;
    run_open_d  = run_open_q;
    run_acc_d   = run_acc_q;
    run_app_d   = run_app_q;
    run_widx_d  = run_widx_q;
    run_rem_d   = run_rem_q;
    idx_d       = idx_q;
    start_d     = start_q;
    n_d         = n_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    case (state_q)
      cbsm_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data_i.command)
            cbsm_pkg::CMD_APPEND, cbsm_pkg::CMD_WRITE: begin
              if (in_data_i.first) begin
                run_acc_d   = eff_acc;
                run_app_d   = eff_app;
                out_valid_d = 1'b1;
                out_data_d.status      = first_status;
                out_data_d.read_byte   = '0;
                out_data_d.start_index = eff_acc ? cbsm_pkg::IDX_FIELD_W'(first_start) : '0;
                out_data_d.last        = 1'b0;
              end
              if (take) begin
                if (eff_rem == '0) begin
                  run_open_d = 1'b0;
                end else begin
                  if (eff_acc) begin
                    run_widx_d = alu_y[IdxW-1:0];
                    if (eff_app) begin
                      tail_d = alu_y[IdxW-1:0];
                      if (LenW'(used_q) < Size) used_d = used_q + 1'b1;
                    end
                  end else begin
                    run_widx_d = eff_widx;
                  end
                  run_rem_d  = eff_rem - 7'd1;
                  run_open_d = (eff_rem != 7'd1);
                end
              end
            end
            cbsm_pkg::CMD_READ: begin
              idx_d = in_data_i.source_index;
              n_d   = len_rd;
              k_d   = '0;
            end
            cbsm_pkg::CMD_MOVE: begin
              idx_d   = in_data_i.source_index;
              start_d = in_data_i.dest_index;
              n_d     = len_mv;
              k_d     = '0;
              if (mv_bad || (len_mv == '0)) begin
                out_valid_d = 1'b1;
                out_data_d.status      = mv_bad ? cbsm_pkg::ST_BAD_ADDR : cbsm_pkg::ST_OK;
                out_data_d.read_byte   = '0;
                out_data_d.start_index = mv_bad ? '0 : in_data_i.dest_index;
                out_data_d.last        = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cbsm_pkg::S_RD_REDUCE: begin
        if (alu_ge) begin
          idx_d = alu_y[cbsm_pkg::IDX_FIELD_W-1:0];
        end else begin
          start_d = idx_q;
        end
      end
      cbsm_pkg::S_RD_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d.status      = cbsm_pkg::ST_OK;
          out_data_d.read_byte   = mem_rdata;
          out_data_d.start_index = start_q;
          out_data_d.last        = k_last;
          idx_d = alu_y[cbsm_pkg::IDX_FIELD_W-1:0];
          k_d   = k_q + 7'd1;
        end
      end
      cbsm_pkg::S_MV_SAVE: begin
        if (k_last) begin
          // source copied out; restart the walk at the destination
          idx_d = start_q;
          k_d   = '0;
        end else begin
          idx_d = alu_y[cbsm_pkg::IDX_FIELD_W-1:0];
          k_d   = k_q + 7'd1;
        end
      end
      cbsm_pkg::S_MV_STORE: begin
        idx_d = alu_y[cbsm_pkg::IDX_FIELD_W-1:0];
        k_d   = k_q + 7'd1;
      end
      cbsm_pkg::S_MV_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d.status      = cbsm_pkg::ST_OK;
          out_data_d.read_byte   = '0;
          out_data_d.start_index = start_q;
          out_data_d.last        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbsm_pkg::S_IDLE;
      base_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      run_open_q  <= 1'b0;
      run_acc_q   <= 1'b0;
      run_app_q   <= 1'b0;
      run_widx_q  <= '0;
      run_rem_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) base_q <= cfg_data_i;
      tail_q      <= tail_d;
      used_q      <= used_d;
      run_open_q  <= run_open_d;
      run_acc_q   <= run_acc_d;
      run_app_q   <= run_app_d;
      run_widx_q  <= run_widx_d;
      run_rem_q   <= run_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    start_q    <= start_d;
    n_q        <= n_d;
    k_q        <= k_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/cbsm_checker.sv =====
// Port-level checks for the circular byte store, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cbsm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cbsm_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cbsm_pkg::out_item_t out_data_o
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // no item is taken while a result is stuck in the output register
  `ASSERT_IMPL(a_no_take_on_stall, out_valid_o && !out_ready_i, !in_ready_o)

  // a read run with bytes to send keeps the input closed next cycle
  `ASSERT_NEXT(a_read_busy,
    in_valid_i && in_ready_o && (in_data_i.command == cbsm_pkg::CMD_READ) &&
    (in_data_i.length != '0), !in_ready_o)

  // the run-end mark only rides on good read results
  `ASSERT_IMPL(a_last_ok, out_valid_o && out_data_o.last,
    out_data_o.status == cbsm_pkg::ST_OK)

endmodule

bind circular_byte_store_with_move cbsm_checker u_cbsm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== sim/circular_byte_store_with_move_tb.sv =====
// Self-checking testbench for circular_byte_store_with_move: directed table, then random runs.
`default_nettype none

module circular_byte_store_with_move_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned PHASE_ITEMS = 45;

  typedef struct {
    cbsm_pkg::in_item_t  item;
    bit                  typed;
    cbsm_pkg::out_item_t res;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [15:0]         cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  cbsm_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cbsm_pkg::out_item_t out_data_o;

  // shadow copy of the block state
  logic [7:0]  store_img [STORE_BYTES];
  int unsigned tail_idx;
  int unsigned used_bytes;
  bit          run_is_open;
  bit          run_ok;
  bit          run_is_append;
  int unsigned run_wr_idx;
  int unsigned run_left;
  logic [15:0] base_addr;

  cbsm_pkg::out_item_t pending_results[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         burst_left     = 0;
  logic [7:0]          ready_pat      = 8'hFF;
  int unsigned         pat_left       = 0;
  cbsm_pkg::out_item_t want;
  row_t                rows[$];

  circular_byte_store_with_move #(
    .STORE_BYTES(STORE_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic cbsm_pkg::in_item_t mk_item(cbsm_pkg::cmd_e c, logic [7:0] d, logic f,
                                                 logic [6:0] len, logic [15:0] tgt,
                                                 logic [5:0] src, logic [5:0] dst);
    cbsm_pkg::in_item_t it;
    it.command        = c;
    it.data_byte      = d;
    it.first          = f;
    it.length         = len;
    it.target_address = tgt;
    it.source_index   = src;
    it.dest_index     = dst;
    return it;
  endfunction

  function automatic cbsm_pkg::out_item_t mk_res(cbsm_pkg::status_e s, logic [7:0] rb,
                                                 logic [5:0] idx, logic l);
    cbsm_pkg::out_item_t r;
    r.status      = s;
    r.read_byte   = rb;
    r.start_index = idx;
    r.last        = l;
    return r;
  endfunction

  function automatic cbsm_pkg::in_item_t rand_item();
    return mk_item(cbsm_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                   16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)));
  endfunction

  task automatic take_run_byte(input logic [7:0] data);
    if (run_left == 0) begin
      run_is_open = 1'b0;
      return;
    end
    if (run_ok) begin
      store_img[run_wr_idx] = data;
      run_wr_idx = (run_wr_idx + 1) % STORE_BYTES;
      if (run_is_append) begin
        tail_idx = run_wr_idx;
        if (used_bytes < STORE_BYTES) used_bytes++;
      end
    end
    run_left--;
    if (run_left == 0) run_is_open = 1'b0;
  endtask

  // updates the shadow state and queues the results the item causes
  task automatic model_store_op(input cbsm_pkg::in_item_t it);
    int unsigned       n, start, k, tgt, src, dst;
    cbsm_pkg::status_e st;
    logic [7:0]        tmp [STORE_BYTES];
    case (it.command)
      cbsm_pkg::CMD_APPEND, cbsm_pkg::CMD_WRITE: begin
        if (!it.first) begin
          if (run_is_open) take_run_byte(it.data_byte);
        end else begin
          n = (it.length == 0) ? 1 : it.length;
          tgt = it.target_address;
          run_is_open = 1'b1;
          run_is_append = (it.command == cbsm_pkg::CMD_APPEND);
          run_left = n;
          st = cbsm_pkg::ST_OK;
          start = 0;
          if (STORE_BYTES - used_bytes < n) st = cbsm_pkg::ST_NO_SPACE;
          else if (it.command == cbsm_pkg::CMD_APPEND) start = tail_idx;
          else if (tgt < base_addr || tgt - base_addr >= STORE_BYTES)
            st = cbsm_pkg::ST_BAD_ADDR;
          else start = tgt - base_addr;
          run_ok = (st == cbsm_pkg::ST_OK);
          run_wr_idx = start;
          pending_results.push_back(mk_res(st, 8'h00, 6'(start), 1'b0));
          take_run_byte(it.data_byte);
        end
      end
      cbsm_pkg::CMD_READ: begin
        n = (it.length > 64) ? 64 : it.length;
        start = it.source_index % STORE_BYTES;
        for (k = 0; k < n; k++) begin
          pending_results.push_back(mk_res(cbsm_pkg::ST_OK,
                                           store_img[(start + k) % STORE_BYTES],
                                           6'(start), k + 1 == n));
        end
      end
      default: begin
        src = it.source_index;
        dst = it.dest_index;
        if (src >= STORE_BYTES || dst >= STORE_BYTES) begin
          pending_results.push_back(mk_res(cbsm_pkg::ST_BAD_ADDR, 8'h00, 6'd0, 1'b0));
        end else begin
          n = (it.length > STORE_BYTES) ? STORE_BYTES : it.length;
          for (k = 0; k < n; k++) tmp[k] = store_img[(src + k) % STORE_BYTES];
          for (k = 0; k < n; k++) store_img[(dst + k) % STORE_BYTES] = tmp[k];
          pending_results.push_back(mk_res(cbsm_pkg::ST_OK, 8'h00, 6'(dst), 1'b0));
        end
      end
    endcase
  endtask

  // sender: bursts of items separated by random gaps
  task automatic send_item(input cbsm_pkg::in_item_t it);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    model_store_op(it);
  endtask

  task automatic hold_until_drained(input int unsigned extra);
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_base(input logic [15:0] value);
    // trailing bytes of a run give no result, so leave room for them to finish
    hold_until_drained(8);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    base_addr = value;
  endtask

  function automatic logic [6:0] write_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return 7'($urandom_range(1, 6));
    if (p < 88) return 7'd0;
    if (p < 96) return 7'($urandom_range(7, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic random_run(input int unsigned append_pct, inout int unsigned counted);
    cbsm_pkg::in_item_t it;
    int unsigned        pick, n, k, i;
    pick = $urandom_range(0, 99);
    it = rand_item();
    if (pick < 8) begin
      // stray run byte
      it.command = cbsm_pkg::cmd_e'($urandom_range(0, 1));
      it.first = 1'b0;
      send_item(it);
    end else if (pick < 55) begin
      it.command = (pick < 8 + append_pct) ? cbsm_pkg::CMD_APPEND : cbsm_pkg::CMD_WRITE;
      it.first = 1'b1;
      it.length = write_len();
      if (it.command == cbsm_pkg::CMD_APPEND && it.length > 4 && $urandom_range(0, 3) != 0)
        it.length = 7'($urandom_range(1, 4));
      if (it.command == cbsm_pkg::CMD_WRITE && $urandom_range(0, 4) != 0)
        it.target_address = base_addr + 16'($urandom_range(0, STORE_BYTES - 1));
      send_item(it);
      counted++;
      n = (it.length == 0) ? 1 : it.length;
      k = n - 1;
      if (k > 16) k = $urandom_range(0, 3);
      else if ($urandom_range(0, 9) == 0) k = $urandom_range(0, k);
      else if ($urandom_range(0, 9) == 0) k = k + 1;
      for (i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = rand_item();
          it.command = cbsm_pkg::CMD_READ;
          it.length = 7'($urandom_range(1, 4));
          send_item(it);
          counted++;
        end
        it = rand_item();
        it.command = cbsm_pkg::cmd_e'($urandom_range(0, 1));
        it.first = 1'b0;
        send_item(it);
        counted++;
      end
    end else if (pick < 80) begin
      it.command = cbsm_pkg::CMD_READ;
      n = $urandom_range(0, 99);
      if (n < 80) it.length = 7'($urandom_range(1, 8));
      else if (n < 85) it.length = 7'd0;
      else if (n < 95) it.length = 7'($urandom_range(9, 64));
      else it.length = 7'($urandom_range(65, 127));
      send_item(it);
      counted++;
    end else begin
      it.command = cbsm_pkg::CMD_MOVE;
      it.length = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 16))
                                             : 7'($urandom_range(17, 127));
      send_item(it);
      counted++;
    end
  endtask

  task automatic note_mismatch(input bit unexpected, input cbsm_pkg::out_item_t exp,
                               input cbsm_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      if (unexpected) begin
        $display("[%0d] unexpected result: status=%0d byte=%02h idx=%0d last=%0b",
                 cycle_count, got.status, got.read_byte, got.start_index, got.last);
      end else begin
        $display("[%0d] mismatch: exp status=%0d byte=%02h idx=%0d last=%0b",
                 cycle_count, exp.status, exp.read_byte, exp.start_index, exp.last);
        $display("[%0d]           got status=%0d byte=%02h idx=%0d last=%0b",
                 cycle_count, got.status, got.read_byte, got.start_index, got.last);
      end
    end
  endtask

  // receiver: rotating stall pattern, replaced now and then
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom_range(0, 255)) | 8'h01);
      pat_left = $urandom_range(64, 256);
    end
    pat_left--;
    out_ready_i <= ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[7:1]};
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch(1'b1, '0, out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.read_byte !== want.read_byte ||
            out_data_o.start_index !== want.start_index || out_data_o.last !== want.last)
          note_mismatch(1'b0, want, out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned        n0, counted, ph;
    logic [15:0]        phase_base [4];
    int unsigned        phase_append [4];

    for (int i = 0; i < STORE_BYTES; i++) store_img[i] = cbsm_pkg::SPACE_CHAR;
    tail_idx = 0;
    used_bytes = 0;
    run_is_open = 1'b0;
    run_ok = 1'b0;
    run_is_append = 1'b0;
    run_wr_idx = 0;
    run_left = 0;
    base_addr = '0;

    // base is 0 for the whole table
    rows.push_back('{mk_item(cbsm_pkg::CMD_READ, 8'h00, 1'b0, 7'd4, 16'h0000, 6'd0, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_OK, cbsm_pkg::SPACE_CHAR, 6'd0, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_READ, 8'hFF, 1'b1, 7'd0, 16'hFFFF, 6'd5, 6'd63),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_READ, 8'h00, 1'b0, 7'd127, 16'h0000, 6'd63, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_OK, cbsm_pkg::SPACE_CHAR, 6'd63, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h00, 1'b1, 7'd3, 16'h0000, 6'd0, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_OK, 8'h00, 6'd0, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'hFF, 1'b0, 7'd0, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    // later byte with the other write command still continues the run
    rows.push_back('{mk_item(cbsm_pkg::CMD_WRITE, 8'hA5, 1'b0, 7'd0, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h5A, 1'b0, 7'd9, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_WRITE, 8'h11, 1'b1, 7'd2, 16'd63, 6'd0, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_OK, 8'h00, 6'd63, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h22, 1'b0, 7'd0, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_WRITE, 8'h00, 1'b1, 7'd1, 16'd64, 6'd0, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_BAD_ADDR, 8'h00, 6'd0, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_WRITE, 8'hFF, 1'b1, 7'd0, 16'hFFFF, 6'd63, 6'd63),
                     1'b1, mk_res(cbsm_pkg::ST_BAD_ADDR, 8'h00, 6'd0, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h77, 1'b1, 7'd127, 16'h0000, 6'd0, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_NO_SPACE, 8'h00, 6'd0, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h78, 1'b0, 7'd0, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h33, 1'b1, 7'd2, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    // new first byte drops the open run
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h44, 1'b1, 7'd1, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_MOVE, 8'h00, 1'b0, 7'd10, 16'h0000, 6'd0, 6'd5),
                     1'b1, mk_res(cbsm_pkg::ST_OK, 8'h00, 6'd5, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_MOVE, 8'h00, 1'b1, 7'd10, 16'h0000, 6'd5, 6'd0),
                     1'b1, mk_res(cbsm_pkg::ST_OK, 8'h00, 6'd0, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_MOVE, 8'h00, 1'b0, 7'd0, 16'h0000, 6'd1, 6'd2),
                     1'b1, mk_res(cbsm_pkg::ST_OK, 8'h00, 6'd2, 1'b0)});
    rows.push_back('{mk_item(cbsm_pkg::CMD_MOVE, 8'h00, 1'b0, 7'd127, 16'h0000, 6'd3, 6'd60),
                     1'b1, mk_res(cbsm_pkg::ST_OK, 8'h00, 6'd60, 1'b0)});
    // read and move in the middle of an open append run
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h55, 1'b1, 7'd3, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_READ, 8'h00, 1'b0, 7'd2, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_APPEND, 8'h66, 1'b0, 7'd0, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_MOVE, 8'h00, 1'b0, 7'd2, 16'h0000, 6'd8, 6'd9),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_WRITE, 8'h67, 1'b0, 7'd0, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});
    rows.push_back('{mk_item(cbsm_pkg::CMD_READ, 8'h00, 1'b0, 7'd64, 16'h0000, 6'd0, 6'd0),
                     1'b0, '0});

    phase_base[0] = 16'hFFFF;  phase_append[0] = 4;
    phase_base[1] = 16'hFFC0;  phase_append[1] = 4;
    phase_base[2] = 16'($urandom_range(0, 65535));  phase_append[2] = 4;
    phase_base[3] = 16'h0001;  phase_append[3] = 30;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_base(16'h0000);

    foreach (rows[i]) begin
      n0 = pending_results.size();
      send_item(rows[i].item);
      if (rows[i].typed && pending_results.size() > n0) pending_results[n0] = rows[i].res;
    end

    for (ph = 0; ph < 4; ph++) begin
      set_base(phase_base[ph]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        random_run(phase_append[ph], counted);
        if ($urandom_range(0, 29) == 0) hold_until_drained(0);
      end
    end

    hold_until_drained(0);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
